// ===== hw/rtl/mpw_pkg.sv =====
// Package for the 2x2 stride-2 max pooling stream block.
// Holds sizes, configuration codes, queue work item and status types.
// No dependencies; compiled first.
package mpw_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned MAX_WIDTH   = 64;
  localparam int unsigned MAX_HEIGHT  = 64;
  localparam int unsigned MAX_MAPS    = 16;
  localparam int unsigned LINE_DEPTH  = MAX_WIDTH / 2;
  localparam int unsigned SLOT_W      = $clog2(LINE_DEPTH);
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned MAP_W       = $clog2(MAX_MAPS);
  localparam int unsigned CNT_W       = $clog2(MAX_MAPS + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 7;
  localparam int unsigned WIDTH_REG_W  = 7;
  localparam int unsigned HEIGHT_REG_W = 7;
  localparam int unsigned COUNT_REG_W  = 5;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 7'd24;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 7'd24;
  localparam logic [COUNT_REG_W-1:0]  COUNT_RESET  = 5'd6;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_MAP_COUNT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_PAIR_FIRST = 2'd0,  // even column: hold sample
    OP_ROW_STORE  = 2'd1,  // odd column, even row: save pair max in line store
    OP_ROW_EMIT   = 2'd2   // odd column, odd row: finish window
  } op_e;

  // clamped map geometry
  typedef struct packed {
    logic [COL_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic [CNT_W-1:0] count;
  } map_cfg_t;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
    logic [SLOT_W-1:0]        slot;
    logic                     last_of_map;
    logic                     last_of_batch;
  } work_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } queue_status_t;

endpackage

// ===== hw/rtl/mpw_if.sv =====
// Stream interfaces for the max pooling block: sample requests in, pooled requests out.
// Depends on mpw_pkg.
interface mpw_sample_if;
  import mpw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface mpw_pool_if;
  import mpw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pooled_value;
  logic                     last_of_map;
  logic                     last_of_batch;

  modport source (output valid, output pooled_value, output last_of_map,
                  output last_of_batch, input ready);
  modport sink   (input valid, input pooled_value, input last_of_map,
                  input last_of_batch, output ready);
endinterface

// ===== hw/rtl/mpw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module mpw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mpw_queue.sv =====
// Short work queue between the classifying front and the executing back.
// Depends on mpw_pkg.
module mpw_queue import mpw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  work_t         work_i,
  input  logic          pop_i,
  output logic          valid_o,
  output work_t         work_o,
  output logic          ready_o,
  output queue_status_t status_o
);

  work_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  always_comb begin
    do_push  = push_i && (count_q != QCNT_W'(QUEUE_DEPTH));
    do_pop   = pop_i && (count_q != '0);
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= work_i;
    end
  end

  assign valid_o        = (count_q != '0);
  assign work_o         = mem_q[rd_ptr_q];
  assign ready_o        = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign status_o.count = count_q;
  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

// ===== hw/rtl/mpw_front.sv =====
// Front end: accepts sample requests, tracks column/row/map position and
// classifies each in-window sample into a work item. Depends on mpw_pkg, mpw_if.
module mpw_front import mpw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  map_cfg_t   cfg_i,
  mpw_sample_if.sink sample_i,
  input  logic       queue_ready_i,
  output logic       push_o,
  output work_t      work_o
);

  logic [COL_W-1:0] col_q, col_d, col_inc, w_use;
  logic [ROW_W-1:0] row_q, row_d, row_inc, h_use;
  logic [MAP_W-1:0] map_q, map_d;
  logic [CNT_W-1:0] map_inc;
  logic             accept, in_window, last_map;

  assign sample_i.ready = queue_ready_i;

  always_comb begin
    accept    = sample_i.valid && queue_ready_i;
    // trailing odd column/row is dropped
    w_use     = {cfg_i.width[COL_W-1:1], 1'b0};
    h_use     = {cfg_i.height[ROW_W-1:1], 1'b0};
    in_window = (col_q < w_use) && (row_q < h_use);
    col_inc   = col_q + 1'b1;
    row_inc   = row_q + 1'b1;
    map_inc   = {1'b0, map_q} + 1'b1;
    last_map  = (row_q == h_use - 1'b1) && (col_q == w_use - 1'b1);

    if (!col_q[0]) begin
      work_o.op = OP_PAIR_FIRST;
    end else if (!row_q[0]) begin
      work_o.op = OP_ROW_STORE;
    end else begin
      work_o.op = OP_ROW_EMIT;
    end
    work_o.value         = sample_i.sample_value;
    work_o.slot          = SLOT_W'(col_q >> 1);
    work_o.last_of_map   = last_map;
    work_o.last_of_batch = last_map && (map_inc >= cfg_i.count);
    push_o               = accept && in_window;
  end

  // position counters; a counter past a shrunken bound wraps on its next step
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    map_d = map_q;
    if (accept) begin
      if (col_inc >= cfg_i.width) begin
        col_d = '0;
        if (row_inc >= cfg_i.height) begin
          row_d = '0;
          map_d = (map_inc >= cfg_i.count) ? '0 : map_inc[MAP_W-1:0];
        end else begin
          row_d = row_inc;
        end
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      map_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      map_q <= map_d;
    end
  end

endmodule

// ===== hw/rtl/mpw_back.sv =====
// Back end: executes queued work items against the pair register and the
// line store, and drives pooled requests. Depends on mpw_pkg, mpw_if, mpw_ram.
module mpw_back import mpw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        work_valid_i,
  input  work_t       work_i,
  output logic        pop_o,
  mpw_pool_if.source  pooled_o
);

  logic signed [DATA_W-1:0] pair_max_q, pair_max_d;
  logic signed [DATA_W-1:0] pair_m;
  logic signed [DATA_W-1:0] line_rdata;
  logic signed [DATA_W-1:0] b_max_q;
  logic                     b_valid_q, b_valid_d;
  logic                     b_lm_q, b_lb_q;
  logic                     can_emit, line_we, line_re;

  always_comb begin
    can_emit = !b_valid_q || pooled_o.ready;
    pair_m   = (work_i.value > pair_max_q) ? work_i.value : pair_max_q;
    case (work_i.op)
      OP_PAIR_FIRST: pop_o = work_valid_i;
      OP_ROW_STORE:  pop_o = work_valid_i;
      OP_ROW_EMIT:   pop_o = work_valid_i && can_emit;
      default:       pop_o = work_valid_i;
    endcase
    line_we    = pop_o && (work_i.op == OP_ROW_STORE);
    line_re    = pop_o && (work_i.op == OP_ROW_EMIT);
    pair_max_d = (pop_o && (work_i.op == OP_PAIR_FIRST)) ? work_i.value : pair_max_q;
    if (line_re) begin
      b_valid_d = 1'b1;
    end else if (pooled_o.ready) begin
      b_valid_d = 1'b0;
    end else begin
      b_valid_d = b_valid_q;
    end
  end

  mpw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (work_i.slot),
    .wdata_i (pair_m),
    .re_i    (line_re),
    .raddr_i (work_i.slot),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_max_q <= '0;
      b_valid_q  <= 1'b0;
    end else begin
      pair_max_q <= pair_max_d;
      b_valid_q  <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_re) begin
      b_max_q <= pair_m;
      b_lm_q  <= work_i.last_of_map;
      b_lb_q  <= work_i.last_of_batch;
    end
  end

  // final compare against the stored top-row pair max; both operands held
  assign pooled_o.valid         = b_valid_q;
  assign pooled_o.pooled_value  = (line_rdata > b_max_q) ? line_rdata : b_max_q;
  assign pooled_o.last_of_map   = b_lm_q;
  assign pooled_o.last_of_batch = b_lb_q;

endmodule

// ===== hw/rtl/max_pool_window_stream.sv =====
// Top level of the 2x2 stride-2 max pooling stream block.
// Depends on mpw_pkg, mpw_if, mpw_queue, mpw_front, mpw_back (and mpw_ram).
//
//   channel    dir  handshake             payload
//   sample_i   in   valid/ready           sample_value (Q8.8 signed)
//   pooled_o   out  valid/ready           pooled_value, last_of_map, last_of_batch
//   cfg        in   cfg_we_i (no ready)   cfg_index_i, cfg_data_i
//
// Sustains one sample request per cycle while the queue has room; the line store
// RAM takes one write or one read per cycle, and one queue entry retires per cycle
// unless an emit waits on a stalled output. A result leaves after the window's
// bottom-right sample is accepted, through a queue push and then a line store read.
// Reset is asynchronous, active low; no clearing pass, the line store is
// written before it is read within a map.
// A 4-entry queue parts front and back; the input stalls only when it fills.
module max_pool_window_stream import mpw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mpw_sample_if.sink            sample_i,
  mpw_pool_if.source            pooled_o
);

  // raw register values as written
  logic [WIDTH_REG_W-1:0]  map_width_q;
  logic [HEIGHT_REG_W-1:0] map_height_q;
  logic [COUNT_REG_W-1:0]  map_count_q;
  map_cfg_t                map_cfg;

  logic          queue_ready, front_push, back_pop, work_valid;
  work_t         front_work, queue_work;
  queue_status_t queue_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= WIDTH_RESET;
      map_height_q <= HEIGHT_RESET;
      map_count_q  <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        CFG_MAP_COUNT:  map_count_q  <= cfg_data_i[COUNT_REG_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // saturate registers into their legal ranges where they are used
  always_comb begin
    if (map_width_q < 2) begin
      map_cfg.width = COL_W'(2);
    end else if (32'(map_width_q) > MAX_WIDTH) begin
      map_cfg.width = COL_W'(MAX_WIDTH);
    end else begin
      map_cfg.width = COL_W'(map_width_q);
    end
    if (map_height_q < 2) begin
      map_cfg.height = ROW_W'(2);
    end else if (32'(map_height_q) > MAX_HEIGHT) begin
      map_cfg.height = ROW_W'(MAX_HEIGHT);
    end else begin
      map_cfg.height = ROW_W'(map_height_q);
    end
    if (map_count_q < 1) begin
      map_cfg.count = CNT_W'(1);
    end else if (32'(map_count_q) > MAX_MAPS) begin
      map_cfg.count = CNT_W'(MAX_MAPS);
    end else begin
      map_cfg.count = CNT_W'(map_count_q);
    end
  end

  mpw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (map_cfg),
    .sample_i      (sample_i),
    .queue_ready_i (queue_ready),
    .push_o        (front_push),
    .work_o        (front_work)
  );

  mpw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_push),
    .work_i   (front_work),
    .pop_i    (back_pop),
    .valid_o  (work_valid),
    .work_o   (queue_work),
    .ready_o  (queue_ready),
    .status_o (queue_status)
  );

  mpw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_i       (queue_work),
    .pop_o        (back_pop),
    .pooled_o     (pooled_o)
  );

`ifndef NO_ASSERTIONS
  // batch end is always a map end
  a_batch_is_map_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pooled_o.valid |-> (!pooled_o.last_of_batch || pooled_o.last_of_map))
    else $error("last_of_batch without last_of_map");

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_push |-> !queue_status.full)
    else $error("work queue overflow");

  // back never retires from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |-> !queue_status.empty)
    else $error("work queue underflow");

  // an emit retired under a stalled output would overwrite the held result
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pooled_o.valid && !pooled_o.ready) |->
      !(back_pop && (queue_work.op == OP_ROW_EMIT)))
    else $error("pooled result overwritten while stalled");
`endif

endmodule
